### hdl/bms_pkg.sv
// ----------------------------------------------------------------------------
// bms_pkg
// Shared types, character codes and the comment/quote context table for the
// bracket match scanner.
// ----------------------------------------------------------------------------
package bms_pkg;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_SEARCH   = 2'd1,
    ST_MATCH    = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  typedef logic [2:0] ctx_t;
  typedef logic [2:0] col_t;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CASE_OFS  = 8'h20;

  localparam col_t COL_BSLASH = 3'd0;
  localparam col_t COL_SLASH  = 3'd1;
  localparam col_t COL_QUOTE  = 3'd2;
  localparam col_t COL_DQUOTE = 3'd3;
  localparam col_t COL_STAR   = 3'd4;
  localparam col_t COL_NL     = 3'd5;
  localparam col_t COL_OTHER  = 3'd6;
  localparam col_t COL_IGNORE = 3'd7;

  // rows 0..7 forward scan, rows 8..15 backward scan; last column is the ignore flag
  localparam ctx_t CTX_TABLE [16][8] = '{
    '{3'd0, 3'd1, 3'd4, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd1, 3'd4, 3'd6, 3'd2, 3'd0, 3'd0, 3'd0},
    '{3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd1},
    '{3'd2, 3'd0, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd1},
    '{3'd5, 3'd4, 3'd0, 3'd4, 3'd4, 3'd0, 3'd4, 3'd1},
    '{3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd1},
    '{3'd7, 3'd6, 3'd6, 3'd0, 3'd6, 3'd0, 3'd6, 3'd1},
    '{3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd1},
    '{3'd0, 3'd1, 3'd4, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd1, 3'd4, 3'd6, 3'd2, 3'd0, 3'd0, 3'd0},
    '{3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd1},
    '{3'd2, 3'd0, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd1},
    '{3'd4, 3'd4, 3'd5, 3'd4, 3'd4, 3'd5, 3'd4, 3'd1},
    '{3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd6, 3'd6, 3'd6, 3'd7, 3'd6, 3'd7, 3'd6, 3'd1},
    '{3'd6, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
  };

  function automatic col_t char_column(input logic [7:0] c);
    col_t col;
    case (c)
      CH_BSLASH: col = COL_BSLASH;
      CH_SLASH:  col = COL_SLASH;
      CH_QUOTE:  col = COL_QUOTE;
      CH_DQUOTE: col = COL_DQUOTE;
      CH_STAR:   col = COL_STAR;
      CH_NL:     col = COL_NL;
      default:   col = COL_OTHER;
    endcase
    return col;
  endfunction

  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
    logic [7:0] f;
    f = c;
    if (en && c >= CH_LC_A && c <= CH_LC_Z) begin
      f = c - CASE_OFS;
    end
    return f;
  endfunction

endpackage

### hdl/bracket_match_scanner.sv
// ----------------------------------------------------------------------------
// bracket_match_scanner
// Comment-aware bracket matcher: tracks C comment, quote and string context
// and nesting depth over a stream of characters until the partner is found.
// ----------------------------------------------------------------------------
// Each beat on the input channel yields exactly one result beat. The context
// table lookup, character compare and nesting count update go combinationally
// straight into the result register, so a beat is accepted every cycle while
// in_stall is low and its result shows in the cycle after. in_stall rises only
// while the result register holds a beat that the sink is stalling. cfg_ready is
// always high; write case_fold only while no search is in flight.
module bracket_match_scanner #(
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_case_fold,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_ch,
  input  logic                   in_start_req,
  input  logic                   in_end_of_text,
  output logic                   out_valid,
  input  logic                   out_stall,
  output bms_pkg::status_t       out_status,
  output logic                   out_ignored,
  output logic                   out_backward,
  output logic [15:0]            out_depth
);
  import bms_pkg::*;

  localparam int DW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic                  fold_r;
  ctx_t                  ctx_r, ctx_nxt;
  logic                  bwd_r, bwd_nxt;
  logic [7:0]            open_r, open_nxt;
  logic [7:0]            close_r, close_nxt;
  logic [COUNT_BITS-1:0] nest_r, nest_nxt;
  logic                  active_r, active_nxt;
  logic                  out_valid_r;
  status_t               status_r, status_nxt;
  logic                  ign_r, ign_nxt;
  logic                  bwd_out_r;
  logic [15:0]           depth_r, depth_nxt;

  logic                  in_acc;
  logic [3:0]            row;
  logic                  row_ign;
  logic [7:0]            ch_f;
  logic [DW-1:0]         nest_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;

  assign row     = {bwd_r, ctx_r};
  assign row_ign = CTX_TABLE[row][COL_IGNORE][0];
  assign ch_f    = fold_char(in_ch, fold_r);

  always_comb begin
    ctx_nxt    = ctx_r;
    bwd_nxt    = bwd_r;
    open_nxt   = open_r;
    close_nxt  = close_r;
    nest_nxt   = nest_r;
    active_nxt = active_r;
    status_nxt = ST_IDLE;
    ign_nxt    = 1'b0;
    if (in_start_req) begin
      open_nxt   = in_ch;
      close_nxt  = in_ch;
      bwd_nxt    = 1'b0;
      case (in_ch)
        CH_LPAREN: close_nxt = CH_RPAREN;
        CH_LT:     close_nxt = CH_GT;
        CH_LBRACK: close_nxt = CH_RBRACK;
        CH_LBRACE: close_nxt = CH_RBRACE;
        CH_RPAREN: begin close_nxt = CH_LPAREN; bwd_nxt = 1'b1; end
        CH_GT:     begin close_nxt = CH_LT;     bwd_nxt = 1'b1; end
        CH_RBRACK: begin close_nxt = CH_LBRACK; bwd_nxt = 1'b1; end
        CH_RBRACE: begin close_nxt = CH_LBRACE; bwd_nxt = 1'b1; end
        default:   close_nxt = in_ch;
      endcase
      ctx_nxt    = '0;
      nest_nxt   = '0;
      active_nxt = 1'b1;
      status_nxt = ST_SEARCH;
    end else if (!active_r) begin
      status_nxt = ST_IDLE;
    end else if (in_end_of_text) begin
      active_nxt = 1'b0;
      status_nxt = ST_MISMATCH;
    end else begin
      ctx_nxt    = CTX_TABLE[row][char_column(in_ch)];
      ign_nxt    = row_ign;
      status_nxt = ST_SEARCH;
      if (!row_ign) begin
        if (ch_f == fold_char(close_r, fold_r)) begin
          if (nest_r == '0) begin
            active_nxt = 1'b0;
            status_nxt = ST_MATCH;
          end else begin
            nest_nxt = nest_r - 1'b1;
          end
        end else if (ch_f == fold_char(open_r, fold_r)) begin
          if (nest_r != COUNT_MAX) begin
            nest_nxt = nest_r + 1'b1;
          end
        end
      end
    end
    nest_ext  = DW'(nest_nxt);
    depth_nxt = (nest_ext > DW'(16'hFFFF)) ? 16'hFFFF : nest_ext[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r      <= 1'b1;
      ctx_r       <= '0;
      bwd_r       <= 1'b0;
      open_r      <= '0;
      close_r     <= '0;
      nest_r      <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fold_r <= cfg_case_fold;
      end
      if (in_acc) begin
        ctx_r       <= ctx_nxt;
        bwd_r       <= bwd_nxt;
        open_r      <= open_nxt;
        close_r     <= close_nxt;
        nest_r      <= nest_nxt;
        active_r    <= active_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r  <= status_nxt;
      ign_r     <= ign_nxt;
      bwd_out_r <= bwd_nxt;
      depth_r   <= depth_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_ignored  = ign_r;
  assign out_backward = bwd_out_r;
  assign out_depth    = depth_r;

endmodule

### bench/bracket_match_scanner_tb.sv
// ----------------------------------------------------------------------------
// bracket_match_scanner_tb
// Self-checking bench for the comment-aware bracket matcher. Every accepted
// character beat runs through a cycle-free software copy of the scanner
// (context table, nesting count, case folding), and each result beat is
// checked field by field in order. Stimulus: a directed opening, then
// random searches under both case_fold settings, a deep-nesting run,
// and random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module bracket_match_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] char_t;

  typedef struct packed {
    bms_pkg::status_t status;
    logic             ignored;
    logic             backward;
    logic [15:0]      depth;
  } scan_report_t;

  localparam char_t C_LPAREN = 8'h28;
  localparam char_t C_RPAREN = 8'h29;
  localparam char_t C_LT     = 8'h3C;
  localparam char_t C_GT     = 8'h3E;
  localparam char_t C_LBRACK = 8'h5B;
  localparam char_t C_RBRACK = 8'h5D;
  localparam char_t C_LBRACE = 8'h7B;
  localparam char_t C_RBRACE = 8'h7D;
  localparam char_t C_BSLASH = 8'h5C;
  localparam char_t C_SLASH  = 8'h2F;
  localparam char_t C_QUOTE  = 8'h27;
  localparam char_t C_DQUOTE = 8'h22;
  localparam char_t C_STAR   = 8'h2A;
  localparam char_t C_NL     = 8'h0A;
  localparam char_t C_LC_A   = 8'h61;
  localparam char_t C_LC_Z   = 8'h7A;
  localparam char_t CASE_BIT = 8'h20;

  localparam logic [2:0] CC_BACKSLASH = 3'd0;
  localparam logic [2:0] CC_SLASH     = 3'd1;
  localparam logic [2:0] CC_QUOTE     = 3'd2;
  localparam logic [2:0] CC_DQUOTE    = 3'd3;
  localparam logic [2:0] CC_STAR      = 3'd4;
  localparam logic [2:0] CC_NEWLINE   = 3'd5;
  localparam logic [2:0] CC_OTHER     = 3'd6;
  localparam logic [2:0] CC_SKIP      = 3'd7;

  localparam logic [15:0] DEPTH_MAX   = 16'hFFFF;
  localparam int          QUIET_LIMIT = 2000;

  // next context per character class; last column flags a skipped character
  localparam logic [2:0] SCAN_CONTEXT [16][8] = '{
    '{3'd0, 3'd1, 3'd4, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd1, 3'd4, 3'd6, 3'd2, 3'd0, 3'd0, 3'd0},
    '{3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd1},
    '{3'd2, 3'd0, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd1},
    '{3'd5, 3'd4, 3'd0, 3'd4, 3'd4, 3'd0, 3'd4, 3'd1},
    '{3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd1},
    '{3'd7, 3'd6, 3'd6, 3'd0, 3'd6, 3'd0, 3'd6, 3'd1},
    '{3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd1},
    '{3'd0, 3'd1, 3'd4, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd1, 3'd4, 3'd6, 3'd2, 3'd0, 3'd0, 3'd0},
    '{3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd1},
    '{3'd2, 3'd0, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd1},
    '{3'd4, 3'd4, 3'd5, 3'd4, 3'd4, 3'd5, 3'd4, 3'd1},
    '{3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd6, 3'd6, 3'd6, 3'd7, 3'd6, 3'd7, 3'd6, 3'd1},
    '{3'd6, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
  };

  localparam char_t OPENERS [4] = '{C_LPAREN, C_LT, C_LBRACK, C_LBRACE};
  localparam char_t CLOSERS [4] = '{C_RPAREN, C_GT, C_RBRACK, C_RBRACE};
  localparam char_t SPECIALS [6] = '{C_SLASH, C_STAR, C_QUOTE, C_DQUOTE, C_BSLASH, C_NL};

  class match_checker;
    logic         fold_en;
    logic [2:0]   ctx;
    logic         backward;
    char_t        open_c;
    char_t        close_c;
    logic [15:0]  nest;
    logic         searching;
    int           faults;
    scan_report_t want[$];

    function new();
      fold_en   = 1'b1;
      ctx       = 3'd0;
      backward  = 1'b0;
      open_c    = 8'h00;
      close_c   = 8'h00;
      nest      = 16'd0;
      searching = 1'b0;
      faults    = 0;
    endfunction

    function automatic logic same_char(char_t a, char_t b);
      char_t fa;
      char_t fb;
      fa = (fold_en && a >= C_LC_A && a <= C_LC_Z) ? a - CASE_BIT : a;
      fb = (fold_en && b >= C_LC_A && b <= C_LC_Z) ? b - CASE_BIT : b;
      return fa == fb;
    endfunction

    function automatic void take_char(char_t c, logic start, logic eot);
      scan_report_t r;
      logic [3:0]   row;
      logic [2:0]   col;
      logic         skip;
      r.ignored = 1'b0;
      if (start) begin
        open_c   = c;
        close_c  = c;
        backward = 1'b0;
        case (c)
          C_LPAREN: close_c = C_RPAREN;
          C_LT:     close_c = C_GT;
          C_LBRACK: close_c = C_RBRACK;
          C_LBRACE: close_c = C_RBRACE;
          C_RPAREN: begin close_c = C_LPAREN; backward = 1'b1; end
          C_GT:     begin close_c = C_LT;     backward = 1'b1; end
          C_RBRACK: begin close_c = C_LBRACK; backward = 1'b1; end
          C_RBRACE: begin close_c = C_LBRACE; backward = 1'b1; end
          default: ;
        endcase
        ctx       = 3'd0;
        nest      = 16'd0;
        searching = 1'b1;
        r.status  = bms_pkg::ST_SEARCH;
      end else if (!searching) begin
        r.status = bms_pkg::ST_IDLE;
      end else if (eot) begin
        searching = 1'b0;
        r.status  = bms_pkg::ST_MISMATCH;
      end else begin
        row  = {backward, ctx};
        skip = SCAN_CONTEXT[row][CC_SKIP][0];
        case (c)
          C_BSLASH: col = CC_BACKSLASH;
          C_SLASH:  col = CC_SLASH;
          C_QUOTE:  col = CC_QUOTE;
          C_DQUOTE: col = CC_DQUOTE;
          C_STAR:   col = CC_STAR;
          C_NL:     col = CC_NEWLINE;
          default:  col = CC_OTHER;
        endcase
        ctx       = SCAN_CONTEXT[row][col];
        r.status  = bms_pkg::ST_SEARCH;
        r.ignored = skip;
        if (!skip) begin
          if (same_char(c, close_c)) begin
            if (nest == 16'd0) begin
              searching = 1'b0;
              r.status  = bms_pkg::ST_MATCH;
            end else begin
              nest = nest - 16'd1;
            end
          end else if (same_char(c, open_c)) begin
            if (nest != DEPTH_MAX) nest = nest + 16'd1;
          end
        end
      end
      r.backward = backward;
      r.depth    = nest;
      want.push_back(r);
    endfunction

    function automatic void check_report(bms_pkg::status_t st, logic ign, logic bw,
                                         logic [15:0] d);
      scan_report_t r;
      if (want.size() == 0) begin
        $error("result beat with no expectation pending");
        faults++;
        return;
      end
      r = want.pop_front();
      if (st !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, st);
        faults++;
      end
      if (ign !== r.ignored) begin
        $error("ignored: expected %0d, got %0d", r.ignored, ign);
        faults++;
      end
      if (bw !== r.backward) begin
        $error("backward: expected %0d, got %0d", r.backward, bw);
        faults++;
      end
      if (d !== r.depth) begin
        $error("depth: expected %0d, got %0d", r.depth, d);
        faults++;
      end
    endfunction

    function automatic int pending();
      return want.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_case_fold;
  logic             in_valid;
  logic             in_stall;
  char_t            in_ch;
  logic             in_start_req;
  logic             in_end_of_text;
  logic             out_valid;
  logic             out_stall;
  bms_pkg::status_t out_status;
  logic             out_ignored;
  logic             out_backward;
  logic [15:0]      out_depth;

  match_checker chk;
  int           quiet_cycles;
  int           beats_sent;
  logic         allow_idle;
  logic         src_idle_on;
  logic         sink_idle_on;

  bracket_match_scanner dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_case_fold  (cfg_case_fold),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .in_start_req   (in_start_req),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_ignored    (out_ignored),
    .out_backward   (out_backward),
    .out_depth      (out_depth)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        chk.check_report(out_status, out_ignored, out_backward, out_depth);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_beat(char_t c, logic start, logic eot);
    in_ch          = c;
    in_start_req   = start;
    in_end_of_text = eot;
    in_valid       = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chk.take_char(c, start, eot);
    beats_sent++;
    @(negedge clk);
    in_valid = 1'b0;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // close any open search, drain, then write the register
  task automatic set_case_fold(logic v);
    if (chk.searching) send_beat(8'h00, 1'b0, 1'b1);
    while (chk.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_case_fold = v;
    cfg_valid     = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    chk.fold_en = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic char_t text_char();
    char_t c;
    case ($urandom_range(0, 15))
      0, 1, 2:  c = chk.open_c;
      3, 4, 5:  c = chk.close_c;
      6:        c = chk.open_c ^ CASE_BIT;
      7:        c = C_SLASH;
      8:        c = C_STAR;
      9:        c = C_QUOTE;
      10:       c = C_DQUOTE;
      11:       c = C_BSLASH;
      12:       c = C_NL;
      13, 14:   c = char_t'($urandom_range(32, 126));
      default:  c = char_t'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  task automatic run_search();
    char_t c;
    int    len;
    src_idle_on  = allow_idle && ($urandom_range(0, 3) != 0);
    sink_idle_on = allow_idle && ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = OPENERS[$urandom_range(0, 3)];
      4, 5:       c = CLOSERS[$urandom_range(0, 3)];
      6:          c = char_t'($urandom_range(C_LC_A, C_LC_Z)) ^
                      (($urandom_range(0, 1) == 1) ? CASE_BIT : 8'h00);
      7:          c = SPECIALS[$urandom_range(0, 5)];
      default:    c = char_t'($urandom_range(0, 255));
    endcase
    send_beat(c, 1'b1, $urandom_range(0, 7) == 0);
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 30);
    for (int i = 0; i < len && chk.searching; i++) begin
      send_beat(text_char(), 1'b0, 1'b0);
    end
    if (chk.searching && $urandom_range(0, 5) != 0) begin
      send_beat(char_t'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  task automatic random_phase(int n);
    int target;
    target = beats_sent + n;
    while (beats_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          send_beat(char_t'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                    $urandom_range(0, 1) == 1);
        end
      end else begin
        run_search();
      end
    end
  endtask

  initial begin
    chk            = new();
    beats_sent     = 0;
    allow_idle     = 1'b1;
    src_idle_on    = 1'b1;
    sink_idle_on   = 1'b1;
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_case_fold  = 1'b0;
    in_valid       = 1'b0;
    in_ch          = 8'h00;
    in_start_req   = 1'b0;
    in_end_of_text = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // idle beats, then start with end of text set
    send_beat(8'hFF, 1'b0, 1'b1);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(C_LPAREN, 1'b1, 1'b1);
    send_beat(C_LPAREN, 1'b0, 1'b0);
    send_beat("a", 1'b0, 1'b0);
    send_beat(C_RPAREN, 1'b0, 1'b0);
    send_beat(C_RPAREN, 1'b0, 1'b0);
    // backward scan
    send_beat(C_RBRACK, 1'b1, 1'b0);
    send_beat(C_RBRACK, 1'b0, 1'b0);
    send_beat(C_LBRACK, 1'b0, 1'b0);
    send_beat(C_LBRACK, 1'b0, 1'b0);
    // bracket inside a comment
    send_beat(C_LBRACE, 1'b1, 1'b0);
    send_beat(C_SLASH, 1'b0, 1'b0);
    send_beat(C_STAR, 1'b0, 1'b0);
    send_beat(C_RBRACE, 1'b0, 1'b0);
    send_beat(C_STAR, 1'b0, 1'b0);
    send_beat(C_SLASH, 1'b0, 1'b0);
    send_beat(C_RBRACE, 1'b0, 1'b0);
    // bracket inside a string with an escape, then end of text
    send_beat(C_LT, 1'b1, 1'b0);
    send_beat(C_DQUOTE, 1'b0, 1'b0);
    send_beat(C_BSLASH, 1'b0, 1'b0);
    send_beat(C_DQUOTE, 1'b0, 1'b0);
    send_beat(C_GT, 1'b0, 1'b0);
    send_beat(C_NL, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    // plain character search, case folded
    send_beat("x", 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat("X", 1'b0, 1'b0);

    set_case_fold(1'b0);
    send_beat("q", 1'b1, 1'b0);
    send_beat("Q", 1'b0, 1'b0);
    send_beat("q", 1'b0, 1'b0);
    random_phase(400);

    set_case_fold(1'b1);
    random_phase(400);

    // drive the nesting count deep and part way back down
    set_case_fold(1'b0);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_beat(C_LPAREN, 1'b1, 1'b0);
    repeat (60) send_beat(C_LPAREN, 1'b0, 1'b0);
    repeat (3) send_beat(C_RPAREN, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    random_phase(350);

    set_case_fold(1'b1);
    allow_idle   = 1'b0;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    random_phase(300);
    if (chk.searching) send_beat(8'h00, 1'b0, 1'b1);

    while (chk.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (chk.faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
